FILE: rtl/lia_pkg.sv
// Package for the listen interval aligner: payload types, outcome codes, defaults.
`timescale 1ns / 1ps
package lia_pkg;

	localparam int FIELD_BITS        = 24;
	localparam int OUTCOME_BITS      = 3;
	localparam int INTERVAL_BITS_DEF = 24;

	typedef enum logic [OUTCOME_BITS-1:0] {
		OUT_REJECTED = 3'd0,
		OUT_ALIGNED  = 3'd1,
		OUT_EXTENDED = 3'd2,
		OUT_REDUCED  = 3'd3,
		OUT_NONE     = 3'd4
	} lia_outcome_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] listen_interval;
		logic [FIELD_BITS-1:0] interval_min;
		logic [FIELD_BITS-1:0] interval_max;
	} lia_req_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] adjusted_interval;
		lia_outcome_t          outcome;
	} lia_rsp_t;

endpackage

FILE: rtl/lia_div.sv
// Restoring radix-2 divider: one quotient bit per cycle, quotient and remainder registered.
`timescale 1ns / 1ps
module lia_div #(
	parameter int W = lia_pkg::INTERVAL_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic          fits;
	logic [W-1:0]  rem_nx;

	// shift in the next dividend bit, subtract when it fits
	assign trial  = {rem_q, quo_q[W-1]};
	assign fits   = (trial >= {1'b0, dvs_q});
	assign rem_nx = fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/listen_interval_aligner_core.sv
// Listen interval aligner top level: request capture, search sequencer, shared divider.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// request  | in        | start & !busy        | listen_interval, interval_min, interval_max
// result   | out       | done (one-cycle)     | adjusted_interval, outcome
// config   | in        | cfg_we               | cfg_wdata = broadcast_interval
//
// Sequencing: a rejected request answers in the cycle after it is taken. When the
// listen interval exceeds or divides the broadcast interval, one division settles it.
// Otherwise the divisor search runs the shared divider once per candidate up to
// sqrt(broadcast) and back down.
// Reset: arst_n clears the broadcast interval to zero and returns the sequencer to idle.
// Stalls: busy holds off requests while one is in progress; the receiver cannot stall,
// so each result shows on the result port for exactly one cycle with done high.
`timescale 1ns / 1ps
module listen_interval_aligner_core #(
	parameter int INTERVAL_BITS = lia_pkg::INTERVAL_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  lia_pkg::lia_req_t                request,
	output logic                             done,
	output lia_pkg::lia_rsp_t                result,
	input  logic                             cfg_we,
	input  logic [lia_pkg::FIELD_BITS-1:0]   cfg_wdata
);

	import lia_pkg::*;

	localparam int W  = INTERVAL_BITS;
	// trial divisor never exceeds floor(sqrt(2^W - 1)) + 1
	localparam int DW = (W + 1) / 2 + 1;
	localparam int SW = W + 2;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV0 = 7'b0000010,
		S_L1   = 7'b0000100,
		S_L1W  = 7'b0001000,
		S_L2   = 7'b0010000,
		S_L2W  = 7'b0100000,
		S_FIN  = 7'b1000000
	} lia_state_t;

	lia_state_t   state_q;
	logic [W-1:0] bc_q;
	logic [W-1:0] uc_q;
	logic [W-1:0] lo_q;
	logic [W-1:0] hi_q;
	logic [W-1:0] qref_q;
	logic [DW-1:0] d_q;
	logic [SW-1:0] sq_q;
	logic [W-1:0] below_co_q;
	logic [W-1:0] above_co_q;
	logic         below_v_q;
	logic         above_v_q;
	logic [W-1:0] res_q;
	lia_outcome_t code_q;
	logic         done_q;

	logic [W-1:0] uc_in;
	logic [W-1:0] lo_in;
	logic [W-1:0] hi_in;
	logic         accept;
	logic         reject;

	logic         div_start;
	logic [W-1:0] div_n;
	logic [W-1:0] div_d;
	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;

	logic [W:0]   ext_val;
	logic [W-1:0] red_val;
	logic [W-1:0] d_w;
	logic [SW-1:0] sq_nx;

	// operands are taken at INTERVAL_BITS bits
	assign uc_in  = W'(request.listen_interval);
	assign lo_in  = W'(request.interval_min);
	assign hi_in  = W'(request.interval_max);
	assign accept = start && state_q == S_IDLE;
	assign reject = (bc_q == '0) || (uc_in == '0) || (lo_in == '0) || (hi_in == '0) ||
	                (uc_in < lo_in) || (uc_in > hi_in);

	assign d_w   = W'(d_q);
	// (d+1)^2 = d^2 + 2d + 1
	assign sq_nx = sq_q + SW'({d_q, 1'b1});

	// next multiple above and the one below, for the long-interval case
	assign ext_val = {1'b0, uc_q} + {1'b0, bc_q} - {1'b0, div_rem};
	assign red_val = uc_q - div_rem;

	// divider operand select: first division from the request, then bc / d
	always_comb begin
		div_start = 1'b0;
		div_n     = bc_q;
		div_d     = d_w;
		unique case (state_q)
			S_IDLE: begin
				div_start = accept && !reject;
				if (uc_in > bc_q) begin
					div_n = uc_in;
					div_d = bc_q;
				end else begin
					div_n = bc_q;
					div_d = uc_in;
				end
			end
			S_L1:    div_start = (sq_q <= SW'(bc_q));
			S_L2:    div_start = (d_q != '0);
			default: div_start = 1'b0;
		endcase
	end

	lia_div #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= '0;
		end else if (cfg_we) begin
			bc_q <= W'(cfg_wdata);
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (reject) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DIV0;
						end
					end
				end
				S_DIV0: begin
					if (div_done) begin
						if (uc_q > bc_q || div_rem == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_L1;
						end
					end
				end
				S_L1: begin
					if (sq_q <= SW'(bc_q)) begin
						state_q <= S_L1W;
					end else begin
						state_q <= S_L2;
					end
				end
				S_L1W: begin
					if (div_done) begin
						if (div_rem == '0 && d_w > qref_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_L1;
						end
					end
				end
				S_L2: begin
					if (d_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_L2W;
					end
				end
				S_L2W: begin
					if (div_done) begin
						if (div_rem == '0 && div_quo > qref_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_L2;
						end
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					uc_q      <= uc_in;
					lo_q      <= lo_in;
					hi_q      <= hi_in;
					below_v_q <= 1'b0;
					above_v_q <= 1'b0;
					if (reject) begin
						res_q  <= '0;
						code_q <= OUT_REJECTED;
					end
				end
			end
			S_DIV0: begin
				if (div_done) begin
					if (uc_q > bc_q) begin
						// keep an exact multiple, else extend to the next one, else reduce to the previous one
						priority if (div_rem == '0) begin
							res_q  <= uc_q;
							code_q <= OUT_ALIGNED;
						end else if (ext_val <= {1'b0, hi_q}) begin
							res_q  <= ext_val[W-1:0];
							code_q <= OUT_EXTENDED;
						end else if (red_val >= lo_q) begin
							res_q  <= red_val;
							code_q <= OUT_REDUCED;
						end else begin
							res_q  <= uc_q;
							code_q <= OUT_NONE;
						end
					end else if (div_rem == '0) begin
						res_q  <= uc_q;
						code_q <= OUT_ALIGNED;
					end else begin
						// search divisors of bc around bc / uc, starting at one
						qref_q <= div_quo;
						d_q    <= DW'(1);
						sq_q   <= SW'(1);
					end
				end
			end
			S_L1: begin
				// past the square root: step back and walk the cofactors upward
				if (!(sq_q <= SW'(bc_q))) begin
					d_q <= d_q - DW'(1);
				end
			end
			S_L1W: begin
				if (div_done) begin
					if (div_rem == '0) begin
						if (d_w <= qref_q) begin
							below_co_q <= div_quo;
							below_v_q  <= 1'b1;
						end else begin
							above_co_q <= div_quo;
							above_v_q  <= 1'b1;
						end
					end
					d_q  <= d_q + DW'(1);
					sq_q <= sq_nx;
				end
			end
			S_L2W: begin
				// cofactor bc / d divides bc exactly when d does, for d up to sqrt(bc)
				if (div_done) begin
					if (div_rem == '0) begin
						if (div_quo <= qref_q) begin
							below_co_q <= d_w;
							below_v_q  <= 1'b1;
						end else begin
							above_co_q <= d_w;
							above_v_q  <= 1'b1;
						end
					end
					d_q <= d_q - DW'(1);
				end
			end
			S_FIN: begin
				// try the shorter interval first, then the longer one
				priority if (above_v_q && above_co_q >= lo_q) begin
					res_q  <= above_co_q;
					code_q <= OUT_REDUCED;
				end else if (below_v_q && below_co_q <= hi_q) begin
					res_q  <= below_co_q;
					code_q <= OUT_EXTENDED;
				end else begin
					res_q  <= uc_q;
					code_q <= OUT_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy                     = (state_q != S_IDLE);
	assign done                     = done_q;
	assign result.adjusted_interval = FIELD_BITS'(res_q);
	assign result.outcome           = code_q;

	// an accepted request either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither answered nor in progress");

	// only a rejection carries a zero interval
	a_zero_iff_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.outcome == OUT_REJECTED) == (result.adjusted_interval == '0)))
		else $error("zero interval and rejection code disagree");

	// a result never appears without a request in flight the cycle before
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a request");

endmodule

FILE: test/lia_result_checker.sv
// Result checker for the listen interval aligner: predicts each result and compares it.
`timescale 1ns / 1ps
module lia_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  lia_pkg::lia_req_t            request,
	input  logic                         done,
	input  lia_pkg::lia_rsp_t            result,
	input  logic                         cfg_we,
	input  logic [lia_pkg::FIELD_BITS-1:0] cfg_wdata,
	output int                           pending,
	output int                           fail_count
);
	import lia_pkg::*;

	logic [FIELD_BITS-1:0] broadcast = '0;
	lia_rsp_t              expected_q[$];
	lia_rsp_t              want;
	int                    errors = 0;

	// Align one listen interval against the broadcast interval.
	function automatic lia_rsp_t predict_alignment(input longint unsigned bc,
			input longint unsigned uc, input longint unsigned lo, input longint unsigned hi);
		longint unsigned r;
		longint unsigned qref;
		longint unsigned d;
		longint unsigned co;
		longint unsigned below;
		longint unsigned above;
		bit              found;
		lia_rsp_t        rsp;
		rsp.adjusted_interval = '0;
		rsp.outcome = OUT_REJECTED;
		if (bc == 0 || uc == 0 || lo == 0 || hi == 0 || uc < lo || uc > hi)
			return rsp;
		if (uc > bc) begin
			r = uc % bc;
			if (r == 0) begin
				rsp.adjusted_interval = FIELD_BITS'(uc);
				rsp.outcome = OUT_ALIGNED;
			end else if (uc + bc - r <= hi) begin
				rsp.adjusted_interval = FIELD_BITS'(uc + bc - r);
				rsp.outcome = OUT_EXTENDED;
			end else if (uc - r >= lo) begin
				rsp.adjusted_interval = FIELD_BITS'(uc - r);
				rsp.outcome = OUT_REDUCED;
			end else begin
				rsp.adjusted_interval = FIELD_BITS'(uc);
				rsp.outcome = OUT_NONE;
			end
		end else if (bc % uc == 0) begin
			rsp.adjusted_interval = FIELD_BITS'(uc);
			rsp.outcome = OUT_ALIGNED;
		end else begin
			// Walk divisors up to the square root, then their cofactors upward.
			qref = bc / uc;
			below = 0;
			above = 0;
			found = 1'b0;
			d = 1;
			while (!found && d * d <= bc) begin
				if (bc % d == 0) begin
					if (d <= qref)
						below = d;
					else begin
						above = d;
						found = 1'b1;
					end
				end
				d++;
			end
			if (!found)
				d--;
			while (!found && d > 0) begin
				co = bc / d;
				if (co != 0 && bc % co == 0) begin
					if (co <= qref)
						below = co;
					else begin
						above = co;
						found = 1'b1;
					end
				end
				d--;
			end
			if (above != 0 && bc / above >= lo) begin
				rsp.adjusted_interval = FIELD_BITS'(bc / above);
				rsp.outcome = OUT_REDUCED;
			end else if (below != 0 && bc / below <= hi) begin
				rsp.adjusted_interval = FIELD_BITS'(bc / below);
				rsp.outcome = OUT_EXTENDED;
			end else begin
				rsp.adjusted_interval = FIELD_BITS'(uc);
				rsp.outcome = OUT_NONE;
			end
		end
		return rsp;
	endfunction

	// Retire results before queuing the request of the same edge; the register
	// write lands last so a request on that edge would see the old value.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			broadcast = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result adjusted=%0d outcome=%0d", $realtime,
							result.adjusted_interval, result.outcome);
				end else begin
					want = expected_q.pop_front();
					if (result.adjusted_interval !== want.adjusted_interval ||
							result.outcome !== want.outcome) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch adjusted exp=%0d act=%0d outcome exp=%0d act=%0d",
								$realtime, want.adjusted_interval, result.adjusted_interval,
								want.outcome, result.outcome);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_alignment(broadcast, request.listen_interval,
					request.interval_min, request.interval_max));
			if (cfg_we)
				broadcast = cfg_wdata;
			pending <= expected_q.size();
		end
		fail_count <= errors;
	end

endmodule

FILE: test/listen_interval_aligner_core_tb.sv
// Testbench top for the listen interval aligner: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module listen_interval_aligner_core_tb;
	import lia_pkg::*;

	localparam logic [FIELD_BITS-1:0] FMAX = '1;
	// Quiet cycles after the last result before a register write or the verdict.
	localparam int SETTLE_CYCLES = 40;
	// Bound on the final wait for outstanding results (a few worst-case searches).
	localparam int DRAIN_LIMIT = 1000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	lia_req_t              request = '0;
	logic                  cfg_we = 1'b0;
	logic [FIELD_BITS-1:0] cfg_wdata = '0;
	logic                  busy;
	logic                  done;
	lia_rsp_t              result;
	int                    pending;
	int                    fail_count;
	int                    burst_left = 0;
	int                    waited;

	always #5 clk = ~clk;

	listen_interval_aligner_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// The checker predicts every accepted request and scores every done strobe.
	lia_result_checker result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.fail_count(fail_count)
	);

	function automatic lia_req_t interval_req(input logic [FIELD_BITS-1:0] uc,
			input logic [FIELD_BITS-1:0] lo, input logic [FIELD_BITS-1:0] hi);
		lia_req_t r;
		r.listen_interval = uc;
		r.interval_min = lo;
		r.interval_max = hi;
		return r;
	endfunction

	// Random value of random bit width, so both tiny and full-width numbers show up.
	function automatic longint unsigned spread_value();
		return $urandom & ((32'd1 << $urandom_range(1, FIELD_BITS)) - 1);
	endfunction

	// Build one request around the broadcast interval. Most are well formed: the listen
	// interval sits near a multiple or a divisor and the bounds enclose it at random
	// distances. The rest are raw noise or carry a zero field. With cheap set, any
	// request that would start a divisor search is pushed out of range instead, which
	// keeps large broadcast intervals from running the long search.
	function automatic lia_req_t shape_request(input longint unsigned bc, input bit cheap);
		longint unsigned uc;
		longint unsigned lo;
		longint unsigned hi;
		int              kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			case ($urandom_range(0, 3))
				0: uc = bc * $urandom_range(1, 9);
				1: uc = bc / $urandom_range(1, 64);
				2: uc = $urandom_range(1, 32'(2 * bc + 1));
				default: uc = spread_value();
			endcase
			if (uc > FMAX)
				uc = FMAX;
			if (uc == 0)
				uc = 1;
			lo = uc - (longint'($urandom_range(0, 32'(uc - 1))) >> $urandom_range(0, 12));
			hi = uc + (longint'($urandom_range(0, 32'(FMAX - uc))) >> $urandom_range(0, 22));
		end else if (kind < 9) begin
			uc = spread_value();
			lo = spread_value();
			hi = spread_value();
		end else begin
			uc = $urandom_range(1, 32'(FMAX));
			lo = 1;
			hi = FMAX;
			case ($urandom_range(0, 2))
				0: uc = 0;
				1: lo = 0;
				default: hi = 0;
			endcase
		end
		if (cheap && uc < bc && lo != 0 && lo <= uc)
			lo = uc + 1;
		return interval_req(FIELD_BITS'(uc), FIELD_BITS'(lo), FIELD_BITS'(hi));
	endfunction

	// Issue one request after a random gap and hold it until the block takes it.
	// Start stays high on return; the next call either lowers it or replaces the
	// request in the same step, so back-to-back requests never glitch start.
	task automatic send_request(input lia_req_t r);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(4, 12);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 13);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and hold until every predicted result has come back, then settle.
	task automatic wait_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the broadcast interval only with the block idle.
	task automatic set_broadcast(input logic [FIELD_BITS-1:0] v);
		wait_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase; now and then pause the sender until the block drains.
	task automatic run_random(input logic [FIELD_BITS-1:0] bc, input int n, input bit cheap);
		set_broadcast(bc);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				wait_results();
			send_request(shape_request(bc, cheap));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Broadcast interval still zero from reset: reject.
		send_request(interval_req(100, 1, FMAX));

		set_broadcast(60);
		// Zero fields, out of range on either side, and inverted bounds.
		send_request(interval_req(0, 1, 100));
		send_request(interval_req(30, 0, 100));
		send_request(interval_req(30, 1, 0));
		send_request(interval_req(20, 30, 100));
		send_request(interval_req(120, 1, 100));
		send_request(interval_req(50, 60, 40));
		// Exact divisor and exact multiple pass unchanged.
		send_request(interval_req(30, 1, 100));
		send_request(interval_req(120, 1, 200));
		// Longer than broadcast: extend, reduce, or no candidate.
		send_request(interval_req(100, 1, 200));
		send_request(interval_req(100, 50, 110));
		send_request(interval_req(100, 90, 110));
		// Shorter than broadcast: divisor search picks reduce, extend, or nothing.
		send_request(interval_req(7, 1, 100));
		send_request(interval_req(7, 7, 100));
		send_request(interval_req(7, 7, 9));
		// Field extremes.
		send_request(interval_req(FMAX, FMAX, FMAX));
		send_request(interval_req(FMAX, 1, FMAX));

		set_broadcast(1);
		send_request(interval_req(5, 1, 10));
		send_request(interval_req(1, 1, 1));

		// Largest broadcast interval; the last two run the divisor search.
		set_broadcast(FMAX);
		send_request(interval_req(FMAX, 1, FMAX));
		send_request(interval_req(24'h800000, 1, FMAX));
		send_request(interval_req(1000, 1, FMAX));

		// Random phases: small broadcast intervals keep the search short; the large one runs cheap.
		run_random($urandom_range(1, 16), 15, 1'b0);
		repeat (2) run_random($urandom_range(2, 4096), 15, 1'b0);
		run_random(720 * $urandom_range(1, 5), 15, 1'b0);
		run_random($urandom_range(24'h800000, 24'hFFFFFE), 10, 1'b1);
		run_random(0, 5, 1'b0);

		// Drain, with a bound so a lost result still ends the run.
		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop: several times the slowest legal run.
	initial begin
		#100000000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lia_pkg.sv
rtl/lia_div.sv
rtl/listen_interval_aligner_core.sv
test/lia_result_checker.sv
test/listen_interval_aligner_core_tb.sv
